### src/assert_macros.svh
// assertion macros shared by the harmonic bond verlet step block
// no dependencies; included by hbvs_ctrl, the module that carries assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked while out of reset
`define HBVS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("hbvs assertion failed");
// property checked on every edge, reset included
`define HBVS_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hbvs assertion failed");
`else
`define HBVS_ASSERT(lbl, clk, rstn, prop)
`define HBVS_ASSERT_NR(lbl, clk, prop)
`endif
`endif

### src/hbvs_pkg.sv
// shared types, codes and constants of the harmonic bond verlet step block
// no dependencies; imported by controller, datapath and top level
`default_nettype none

package hbvs_pkg;

  localparam int unsigned MAX_ATOMS_DEF     = 64;
  localparam int unsigned MAX_NEIGHBORS_DEF = 4;
  localparam int unsigned FRAC_BITS_DEF     = 16;

  localparam int unsigned DT2_FRAC   = 48;
  localparam int unsigned FORCE_W    = 48;
  localparam int unsigned DIV_W      = 72;
  localparam int unsigned ACC_W      = 68;
  localparam int unsigned ITER_W     = 7;
  localparam int unsigned SQ_STEPS   = 3;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned MUL_STEPS  = 4;
  localparam int unsigned DIV_STEPS  = DIV_W;

  localparam int unsigned IN_DATA_W  = 248;
  localparam int unsigned OUT_DATA_W = 152;

  // configuration register indexes
  localparam logic [1:0] CFG_ATOM_COUNT = 2'd0;
  localparam logic [1:0] CFG_DT2        = 2'd1;

  typedef enum logic [1:0] {
    CMD_LOAD_ATOM = 2'd0,
    CMD_LOAD_BOND = 2'd1,
    CMD_RUN_STEP  = 2'd2,
    CMD_READ_ATOM = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LD_ATOM,
    OP_LD_BOND,
    OP_SET_RD,
    OP_EMIT_RD,
    OP_STEP_INIT,
    OP_F_ATOM,
    OP_BADDR,
    OP_NEXT_L,
    OP_SET_RB,
    OP_DIFF,
    OP_SQ,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_PROD,
    OP_DIV_STEP,
    OP_RZ,
    OP_KLO,
    OP_KHI,
    OP_F_STORE,
    OP_U_ATOM,
    OP_MUL,
    OP_DIV_INIT_A,
    OP_EMIT_STEP
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_WAIT,
    S_RD_EMIT,
    S_F_ATOM,
    S_F_AWAIT,
    S_F_BCHK,
    S_F_BWAIT,
    S_F_PART,
    S_F_CWAIT,
    S_F_DIFF,
    S_F_SQ,
    S_F_SQRT0,
    S_F_SQRT,
    S_F_LEN,
    S_F_DIV,
    S_F_RZ,
    S_F_KLO,
    S_F_KHI,
    S_F_STORE,
    S_U_ATOM,
    S_U_WAIT,
    S_U_MUL,
    S_U_DIV0,
    S_U_DIV,
    S_U_EMIT
  } state_e;

  typedef struct packed {
    dp_op_e              op;
    logic [ITER_W-1:0]   iter;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic step_empty;
    logic l_done;
    logic partner_ok;
    logic len_zero;
    logic i_last;
    logic out_busy;
  } dp_sts_t;

  typedef struct packed {
    logic [5:0]  atom_index;
    logic [1:0]  slot_index;
    logic [2:0]  neighbor_count;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] prev_z;
    logic [31:0] atom_mass;
    logic [5:0]  partner_index;
    logic [31:0] spring_const;
    logic [31:0] rest_length;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         out_atom;
    logic [31:0]        out_x;
    logic [31:0]        out_y;
    logic [31:0]        out_z;
    logic [FORCE_W-1:0] out_force_z;
    logic               last;
  } out_item_t;

endpackage

`default_nettype wire

### src/harmonic_bond_verlet_step.sv
// Read atom: the command beat sets the read address, the stores are read into registers,
// then the result beat is loaded once the output register is free. Loads are written as
// taken. Step: per bond a 32-step square root and 72-step divider for forces (a partner not
// in use or a zero length ends the bond early), then per atom a 72-step divider for the z
// update, plus output stalls; one result beat per atom. Items are taken one at a time.
// Reset: asynchronous, active low; clears control, config (atom_count 1, dt^2 0)
// and neighbor counts; position, mass, bond and force stores are not cleared.
`default_nettype none

module harmonic_bond_verlet_step
  import hbvs_pkg::*;
#(
  parameter int unsigned MAX_ATOMS     = MAX_ATOMS_DEF,
  parameter int unsigned MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
  parameter int unsigned FRAC_BITS     = FRAC_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // atom_index, slot_index, neighbor_count, pos_x, pos_y, pos_z, prev_z,
  // atom_mass, partner_index, spring_const, rest_length, zero pad
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // cmd
  input  wire logic [1:0]            s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // out_atom, out_x, out_y, out_z, out_force_z, zero pad
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tlast,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [47:0]           cfg_data_i
);

  in_item_t  in_item;
  out_item_t out_item;
  dp_cmd_t   dp_cmd;
  dp_sts_t   dp_sts;

  // unpack the input beat
  assign in_item.atom_index     = s_axis_tdata[5:0];
  assign in_item.slot_index     = s_axis_tdata[7:6];
  assign in_item.neighbor_count = s_axis_tdata[10:8];
  assign in_item.pos_x          = s_axis_tdata[42:11];
  assign in_item.pos_y          = s_axis_tdata[74:43];
  assign in_item.pos_z          = s_axis_tdata[106:75];
  assign in_item.prev_z         = s_axis_tdata[138:107];
  assign in_item.atom_mass      = s_axis_tdata[170:139];
  assign in_item.partner_index  = s_axis_tdata[176:171];
  assign in_item.spring_const   = s_axis_tdata[208:177];
  assign in_item.rest_length    = s_axis_tdata[240:209];

  assign cfg_ready_o = 1'b1;

  hbvs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  hbvs_dp #(
    .MAX_ATOMS     (MAX_ATOMS),
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .FRAC_BITS     (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .in_item_i   (in_item),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item)
  );

  // pack the result beat
  assign m_axis_tdata = {2'b00, out_item.out_force_z, out_item.out_z, out_item.out_y,
                         out_item.out_x, out_item.out_atom};
  assign m_axis_tlast = out_item.last;

endmodule

`default_nettype wire

### src/hbvs_ctrl.sv
// sequencer of the harmonic bond verlet step block: commands the datapath
// depends on hbvs_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module hbvs_ctrl
  import hbvs_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire logic [1:0] in_cmd_i,
  output logic         in_ready_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  state_e              state_q, state_d;
  logic [ITER_W-1:0]   iter_q, iter_d;

  // state and iteration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d    = state_q;
    iter_d     = iter_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.iter = iter_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        iter_d     = '0;
        if (in_valid_i) begin
          unique case (cmd_e'(in_cmd_i))
            CMD_LOAD_ATOM: cmd_o.op = OP_LD_ATOM;
            CMD_LOAD_BOND: cmd_o.op = OP_LD_BOND;
            CMD_READ_ATOM: begin
              if (sts_i.idx_ok) begin
                cmd_o.op = OP_SET_RD;
                state_d  = S_RD_WAIT;
              end
            end
            CMD_RUN_STEP: begin
              if (!sts_i.step_empty) begin
                cmd_o.op = OP_STEP_INIT;
                state_d  = S_F_ATOM;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD_WAIT: state_d = S_RD_EMIT;
      S_RD_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_EMIT_RD;
          state_d  = S_IDLE;
        end
      end
      S_F_ATOM: begin
        cmd_o.op = OP_F_ATOM;
        state_d  = S_F_AWAIT;
      end
      S_F_AWAIT: state_d = S_F_BCHK;
      S_F_BCHK: begin
        if (sts_i.l_done) begin
          state_d = S_F_STORE;
        end else begin
          cmd_o.op = OP_BADDR;
          state_d  = S_F_BWAIT;
        end
      end
      S_F_BWAIT: state_d = S_F_PART;
      S_F_PART: begin
        if (!sts_i.partner_ok) begin
          cmd_o.op = OP_NEXT_L;
          state_d  = S_F_BCHK;
        end else begin
          cmd_o.op = OP_SET_RB;
          state_d  = S_F_CWAIT;
        end
      end
      S_F_CWAIT: state_d = S_F_DIFF;
      S_F_DIFF: begin
        cmd_o.op = OP_DIFF;
        iter_d   = '0;
        state_d  = S_F_SQ;
      end
      S_F_SQ: begin
        cmd_o.op = OP_SQ;
        if (iter_q == ITER_W'(SQ_STEPS - 1)) begin
          iter_d  = '0;
          state_d = S_F_SQRT0;
        end else begin
          iter_d = iter_q + ITER_W'(1);
        end
      end
      S_F_SQRT0: begin
        cmd_o.op = OP_SQRT_INIT;
        state_d  = S_F_SQRT;
      end
      S_F_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        if (iter_q == ITER_W'(SQRT_STEPS - 1)) begin
          iter_d  = '0;
          state_d = S_F_LEN;
        end else begin
          iter_d = iter_q + ITER_W'(1);
        end
      end
      S_F_LEN: begin
        if (sts_i.len_zero) begin
          cmd_o.op = OP_NEXT_L;
          state_d  = S_F_BCHK;
        end else begin
          cmd_o.op = OP_PROD;
          state_d  = S_F_DIV;
        end
      end
      S_F_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (iter_q == ITER_W'(DIV_STEPS - 1)) begin
          iter_d  = '0;
          state_d = S_F_RZ;
        end else begin
          iter_d = iter_q + ITER_W'(1);
        end
      end
      S_F_RZ: begin
        cmd_o.op = OP_RZ;
        state_d  = S_F_KLO;
      end
      S_F_KLO: begin
        cmd_o.op = OP_KLO;
        state_d  = S_F_KHI;
      end
      S_F_KHI: begin
        cmd_o.op = OP_KHI;
        state_d  = S_F_BCHK;
      end
      S_F_STORE: begin
        cmd_o.op = OP_F_STORE;
        state_d  = sts_i.i_last ? S_U_ATOM : S_F_ATOM;
      end
      S_U_ATOM: begin
        cmd_o.op = OP_U_ATOM;
        iter_d   = '0;
        state_d  = S_U_WAIT;
      end
      S_U_WAIT: state_d = S_U_MUL;
      S_U_MUL: begin
        cmd_o.op = OP_MUL;
        if (iter_q == ITER_W'(MUL_STEPS - 1)) begin
          iter_d  = '0;
          state_d = S_U_DIV0;
        end else begin
          iter_d = iter_q + ITER_W'(1);
        end
      end
      S_U_DIV0: begin
        cmd_o.op = OP_DIV_INIT_A;
        state_d  = S_U_DIV;
      end
      S_U_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (iter_q == ITER_W'(DIV_STEPS - 1)) begin
          iter_d  = '0;
          state_d = S_U_EMIT;
        end else begin
          iter_d = iter_q + ITER_W'(1);
        end
      end
      S_U_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_EMIT_STEP;
          state_d  = sts_i.i_last ? S_IDLE : S_U_ATOM;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // a result beat is only loaded into a free output register
  `HBVS_ASSERT(a_emit_free, clk_i, rst_ni, (cmd_o.op == OP_EMIT_STEP || cmd_o.op == OP_EMIT_RD) |-> !sts_i.out_busy)
  // the divider never runs past its step count
  `HBVS_ASSERT_NR(a_div_bound, clk_i, (state_q == S_F_DIV || state_q == S_U_DIV) |-> (iter_q < ITER_W'(DIV_STEPS)))
  // a step with no atoms in use leaves the sequencer idle
  `HBVS_ASSERT(a_empty_step, clk_i, rst_ni, (state_q == S_IDLE && in_valid_i && in_cmd_i == CMD_RUN_STEP && sts_i.step_empty) |=> (state_q == S_IDLE))

endmodule

`default_nettype wire

### src/hbvs_dp.sv
// datapath of the harmonic bond verlet step block: atom and bond stores,
// square root, multiplier, shared divider steps, output register; uses hbvs_pkg
`default_nettype none

module hbvs_dp
  import hbvs_pkg::*;
#(
  parameter int unsigned MAX_ATOMS     = MAX_ATOMS_DEF,
  parameter int unsigned MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
  parameter int unsigned FRAC_BITS     = FRAC_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire dp_cmd_t    cmd_i,
  output dp_sts_t         sts_o,
  input  wire in_item_t   in_item_i,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [47:0] cfg_data_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output out_item_t       out_item_o
);

  localparam int unsigned AW   = $clog2(MAX_ATOMS);
  localparam int unsigned NAW  = AW + 1;
  localparam int unsigned CW   = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned NB   = MAX_ATOMS * MAX_NEIGHBORS;
  localparam int unsigned BAW  = (NB > 1) ? $clog2(NB) : 1;
  localparam int unsigned ASH  = DT2_FRAC - FRAC_BITS;
  localparam logic signed [ACC_W-1:0] F_MAX = ACC_W'(64'sh7FFF_FFFF_FFFF);
  localparam logic signed [ACC_W-1:0] F_MIN = -F_MAX - ACC_W'(1);
  localparam logic signed [43:0] Z_MAX = 44'sh0_7FFF_FFFF;
  localparam logic signed [43:0] Z_MIN = -Z_MAX - 44'sd1;

  // configuration registers
  logic [6:0]  atom_count_q;
  logic [47:0] dt2_q;

  // stores
  logic [31:0]        mem_x  [MAX_ATOMS];
  logic [31:0]        mem_y  [MAX_ATOMS];
  logic [31:0]        mem_z  [MAX_ATOMS];
  logic [31:0]        mem_pz [MAX_ATOMS];
  logic [31:0]        mem_m  [MAX_ATOMS];
  logic [CW-1:0]      mem_cnt[MAX_ATOMS];
  logic [FORCE_W-1:0] mem_f  [MAX_ATOMS];
  logic [69:0]        mem_bond[NB];
  logic [MAX_ATOMS-1:0] cnt_vld_q;

  // read addresses and registered read data
  logic [AW-1:0]  ra_q, rb_q;
  logic [BAW-1:0] ba_q;
  logic [31:0]    xa_q, ya_q, za_q, pza_q, ma_q, xb_q, yb_q, zb_q;
  logic [FORCE_W-1:0] fa_q;
  logic [CW-1:0]  cnt_rd_q;
  logic [69:0]    bond_q;

  // loop control
  logic [NAW-1:0] n_q, i_q;
  logic [CW-1:0]  l_q;

  // working registers
  logic [30:0]    bx_q, by_q, bz_q;
  logic [32:0]    dz_q;
  logic [63:0]    sum_q;
  logic [63:0]    sv_q, sr_q, sb_q;
  logic [DIV_W-1:0] dn_q;
  logic [31:0]    dd_q, rm_q;
  logic [33:0]    rzm_q;
  logic           rzpos_q;
  logic [63:0]    kp_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [95:0]    pm_q;
  logic           out_valid_q;
  out_item_t      out_q;

  // combinational helpers
  logic           atom_ok, slot_ok;
  logic [AW-1:0]  wa;
  logic [BAW-1:0] wba;
  logic [CW-1:0]  nc_sat;
  logic [6:0]     n_eff;
  logic [5:0]     b_partner;
  logic [31:0]    b_spring, b_rest;
  logic [32:0]    dx, dy, dz, ax, ay, az;
  logic           hshift;
  logic [30:0]    sq_sel;
  logic [63:0]    sq_t;
  logic [32:0]    div_sh;
  logic           div_ge;
  logic signed [34:0] rz;
  logic [33:0]    khi;
  logic [63:0]    kfull, kq;
  logic [FORCE_W-1:0] fsat;
  logic           fneg;
  logic [47:0]    fmag;
  logic [23:0]    mul_a, mul_b;
  logic [47:0]    mul_p;
  logic [95:0]    mul_sh;
  logic [40:0]    acc_cap;
  logic signed [43:0] acc_s, z_new;
  logic [31:0]    z_sat;

  assign atom_ok   = (7'(in_item_i.atom_index) < 7'(MAX_ATOMS));
  assign slot_ok   = (4'(in_item_i.slot_index) < 4'(MAX_NEIGHBORS));
  assign wa        = in_item_i.atom_index[AW-1:0];
  assign wba       = BAW'(BAW'(wa) * BAW'(MAX_NEIGHBORS) + BAW'(in_item_i.slot_index));
  assign nc_sat    = (4'(in_item_i.neighbor_count) > 4'(MAX_NEIGHBORS)) ?
                     CW'(MAX_NEIGHBORS) : CW'(in_item_i.neighbor_count);
  assign n_eff     = (atom_count_q > 7'(MAX_ATOMS)) ? 7'(MAX_ATOMS) : atom_count_q;
  assign b_partner = bond_q[69:64];
  assign b_spring  = bond_q[63:32];
  assign b_rest    = bond_q[31:0];

  // position differences, halved when any component reaches 2^31
  always_comb begin
    dx = {xa_q[31], xa_q} - {xb_q[31], xb_q};
    dy = {ya_q[31], ya_q} - {yb_q[31], yb_q};
    dz = {za_q[31], za_q} - {zb_q[31], zb_q};
    ax = dx[32] ? -dx : dx;
    ay = dy[32] ? -dy : dy;
    az = dz[32] ? -dz : dz;
    hshift = ax[31] | ay[31] | az[31];
  end

  // squared length term, one component a cycle
  always_comb begin
    case (cmd_i.iter[1:0])
      2'd0:    sq_sel = bx_q;
      2'd1:    sq_sel = by_q;
      default: sq_sel = bz_q;
    endcase
    sq_t = 64'(sq_sel * sq_sel);
  end

  // one restoring divider step
  assign div_sh = {rm_q, dn_q[DIV_W-1]};
  assign div_ge = (div_sh >= {1'b0, dd_q});

  // bond stretch along z and spring term
  always_comb begin
    if (dz_q[32]) begin
      rz = $signed({{2{dz_q[32]}}, dz_q}) + $signed({3'b0, dn_q[31:0]});
    end else begin
      rz = $signed({{2{dz_q[32]}}, dz_q}) - $signed({3'b0, dn_q[31:0]});
    end
    khi   = (rzm_q[32] ? 34'(b_spring) : 34'd0) + (rzm_q[33] ? {1'b0, b_spring, 1'b0} : 34'd0);
    kfull = kp_q + {khi[31:0], 32'd0};
    kq    = kfull >> FRAC_BITS;
  end

  // force sum saturated to the stored width
  always_comb begin
    if (acc_q > F_MAX) begin
      fsat = FORCE_W'(F_MAX);
    end else if (acc_q < F_MIN) begin
      fsat = FORCE_W'(F_MIN);
    end else begin
      fsat = FORCE_W'(acc_q);
    end
  end

  // force times dt^2, one 24x24 partial product a cycle
  always_comb begin
    fneg = fa_q[FORCE_W-1];
    fmag = fneg ? -fa_q : fa_q;
    mul_a = cmd_i.iter[1] ? fmag[47:24] : fmag[23:0];
    mul_b = cmd_i.iter[0] ? dt2_q[47:24] : dt2_q[23:0];
    mul_p = mul_a * mul_b;
    case (cmd_i.iter[1:0])
      2'd0:    mul_sh = 96'(mul_p);
      2'd3:    mul_sh = {mul_p, 48'd0};
      default: mul_sh = {24'd0, mul_p, 24'd0};
    endcase
  end

  // capped acceleration and new z
  always_comb begin
    if (ma_q == 32'd0 || fa_q == '0) begin
      acc_cap = '0;
    end else if (dn_q[DIV_W-1:40] != '0) begin
      acc_cap = {1'b1, 40'd0};
    end else begin
      acc_cap = dn_q[40:0];
    end
    acc_s = fneg ? -$signed({3'b0, acc_cap}) : $signed({3'b0, acc_cap});
    z_new = ($signed({{12{za_q[31]}}, za_q}) <<< 1) - $signed({{12{pza_q[31]}}, pza_q}) + acc_s;
    if (z_new > Z_MAX) begin
      z_sat = 32'h7FFF_FFFF;
    end else if (z_new < Z_MIN) begin
      z_sat = 32'h8000_0000;
    end else begin
      z_sat = z_new[31:0];
    end
  end

  // status to the sequencer
  assign sts_o.idx_ok     = atom_ok;
  assign sts_o.step_empty = (atom_count_q == 7'd0);
  assign sts_o.l_done     = (l_q >= cnt_rd_q);
  assign sts_o.partner_ok = (7'(b_partner) < 7'(n_q));
  assign sts_o.len_zero   = (sr_q == 64'd0);
  assign sts_o.i_last     = ((i_q + NAW'(1)) == n_q);
  assign sts_o.out_busy   = out_valid_q & ~out_ready_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atom_count_q <= 7'd1;
      dt2_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ATOM_COUNT: atom_count_q <= cfg_data_i[6:0];
        CFG_DT2:        dt2_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // neighbor count valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
    end else if (cmd_i.op == OP_LD_ATOM && atom_ok) begin
      cnt_vld_q[wa] <= 1'b1;
    end
  end

  // atom stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LD_ATOM && atom_ok) begin
      mem_x[wa]   <= in_item_i.pos_x;
      mem_y[wa]   <= in_item_i.pos_y;
      mem_z[wa]   <= in_item_i.pos_z;
      mem_pz[wa]  <= in_item_i.prev_z;
      mem_m[wa]   <= in_item_i.atom_mass;
      mem_cnt[wa] <= nc_sat;
    end else if (cmd_i.op == OP_EMIT_STEP) begin
      mem_z[ra_q]  <= z_sat;
      mem_pz[ra_q] <= za_q;
    end
    if (cmd_i.op == OP_F_STORE) begin
      mem_f[ra_q] <= fsat;
    end
    xa_q     <= mem_x[ra_q];
    ya_q     <= mem_y[ra_q];
    za_q     <= mem_z[ra_q];
    pza_q    <= mem_pz[ra_q];
    ma_q     <= mem_m[ra_q];
    fa_q     <= mem_f[ra_q];
    cnt_rd_q <= cnt_vld_q[ra_q] ? mem_cnt[ra_q] : '0;
    xb_q     <= mem_x[rb_q];
    yb_q     <= mem_y[rb_q];
    zb_q     <= mem_z[rb_q];
  end

  // bond store
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LD_BOND && atom_ok && slot_ok) begin
      mem_bond[wba] <= {in_item_i.partner_index, in_item_i.spring_const,
                        in_item_i.rest_length};
    end
    bond_q <= mem_bond[ba_q];
  end

  // loop control and addresses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ra_q <= '0;
      rb_q <= '0;
      ba_q <= '0;
      n_q  <= '0;
      i_q  <= '0;
      l_q  <= '0;
    end else begin
      case (cmd_i.op)
        OP_SET_RD:    ra_q <= wa;
        OP_STEP_INIT: begin
          n_q <= NAW'(n_eff);
          i_q <= '0;
        end
        OP_F_ATOM: begin
          ra_q <= i_q[AW-1:0];
          l_q  <= '0;
        end
        OP_BADDR:     ba_q <= BAW'(BAW'(ra_q) * BAW'(MAX_NEIGHBORS) + BAW'(l_q));
        OP_SET_RB:    rb_q <= b_partner[AW-1:0];
        OP_NEXT_L, OP_KHI: l_q <= l_q + CW'(1);
        OP_F_STORE, OP_EMIT_STEP: i_q <= sts_o.i_last ? '0 : i_q + NAW'(1);
        OP_U_ATOM:    ra_q <= i_q[AW-1:0];
        default: ;
      endcase
    end
  end

  // arithmetic working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_F_ATOM: acc_q <= '0;
      OP_DIFF: begin
        bx_q <= hshift ? ax[31:1] : ax[30:0];
        by_q <= hshift ? ay[31:1] : ay[30:0];
        bz_q <= hshift ? az[31:1] : az[30:0];
        dz_q <= dz;
      end
      OP_SQ: sum_q <= ((cmd_i.iter == '0) ? 64'd0 : sum_q) + sq_t;
      OP_SQRT_INIT: begin
        sv_q <= sum_q;
        sr_q <= '0;
        sb_q <= 64'd1 << 62;
      end
      OP_SQRT_STEP: begin
        if (sv_q >= sr_q + sb_q) begin
          sv_q <= sv_q - (sr_q + sb_q);
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
      end
      OP_PROD: begin
        dn_q <= DIV_W'(bz_q * b_rest);
        dd_q <= sr_q[31:0];
        rm_q <= '0;
      end
      OP_DIV_STEP: begin
        rm_q <= div_ge ? 32'(div_sh - {1'b0, dd_q}) : div_sh[31:0];
        dn_q <= {dn_q[DIV_W-2:0], div_ge};
      end
      OP_RZ: begin
        rzm_q   <= rz[34] ? 34'(-rz) : 34'(rz);
        rzpos_q <= ~rz[34] && (rz != '0);
      end
      OP_KLO: kp_q <= b_spring * rzm_q[31:0];
      OP_KHI: begin
        if (rzpos_q) begin
          acc_q <= acc_q - $signed({{(ACC_W-64){1'b0}}, kq});
        end else begin
          acc_q <= acc_q + $signed({{(ACC_W-64){1'b0}}, kq});
        end
      end
      OP_MUL: pm_q <= ((cmd_i.iter == '0) ? 96'd0 : pm_q) + mul_sh;
      OP_DIV_INIT_A: begin
        dn_q <= DIV_W'(pm_q >> ASH);
        dd_q <= ma_q;
        rm_q <= '0;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT_RD || cmd_i.op == OP_EMIT_STEP) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EMIT_RD || cmd_i.op == OP_EMIT_STEP) begin
      out_q.out_atom    <= 6'(ra_q);
      out_q.out_x       <= xa_q;
      out_q.out_y       <= ya_q;
      out_q.out_z       <= (cmd_i.op == OP_EMIT_STEP) ? z_sat : za_q;
      out_q.out_force_z <= fa_q;
      out_q.last        <= (cmd_i.op == OP_EMIT_RD) | sts_o.i_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

### tb/harmonic_bond_verlet_step_tb.sv
// self-checking testbench for the harmonic bond verlet step block
// depends on hbvs_pkg and harmonic_bond_verlet_step; a beat-driven predictor checks every beat
`timescale 1ns / 100ps

module harmonic_bond_verlet_step_tb;
  import hbvs_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 3000000;
  localparam int unsigned IDLE_PAUSE   = 100;
  localparam int unsigned LONG_HOLD    = 3000;
  localparam longint      FORCE_HI     = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      FORCE_LO     = -FORCE_HI - 1;
  localparam longint      Z_HI         = 64'sh0000_0000_7FFF_FFFF;
  localparam longint      Z_LO         = -Z_HI - 1;

  typedef struct {
    cmd_e        cmd;
    logic [5:0]  atom;
    logic [1:0]  slot;
    logic [2:0]  nc;
    logic [31:0] x, y, z, pz, mass;
    logic [5:0]  part;
    logic [31:0] k, r0;
  } beat_t;

  typedef struct {
    logic [5:0]  atom;
    logic [31:0] x, y, z;
    logic [47:0] f;
    logic        last;
  } atom_res_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [47:0] val;
    beat_t       b;
    bit          typed;
    logic [31:0] tz;
    logic [47:0] tf;
  } row_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [47:0] cfg_data_i;

  harmonic_bond_verlet_step DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // shadow copy of the block state
  logic signed [31:0] sh_x[64], sh_y[64], sh_z[64], sh_zold[64];
  logic [31:0]        sh_mass[64];
  logic [2:0]         sh_cnt[64];
  logic [5:0]         sh_part[256];
  logic [31:0]        sh_k[256], sh_r0[256];
  logic signed [47:0] sh_fz[64];
  logic [6:0]         sh_atoms;
  logic [47:0]        sh_dt2;

  atom_res_t atom_results_q[$];
  row_t      dir_rows[$];
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  bit        hold_req = 0;

  // clock and cycle count
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit quiet_phase();
    return ((cycle_cnt / 400) % 5) == 0;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom % 16;
    if (quiet_phase() || r < 9) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // summed z force of one atom over its bonds
  function automatic logic signed [47:0] bond_force(int a, int n);
    longint acc, dx, dy, dz, rz;
    longint unsigned ax, ay, az, len, x0, q;
    int idx, p, s;
    acc = 0;
    for (int l = 0; l < sh_cnt[a]; l++) begin
      idx = a * 4 + l;
      p = sh_part[idx];
      if (p < n) begin
        dx = longint'(sh_x[a]) - longint'(sh_x[p]);
        dy = longint'(sh_y[a]) - longint'(sh_y[p]);
        dz = longint'(sh_z[a]) - longint'(sh_z[p]);
        ax = mag(dx); ay = mag(dy); az = mag(dz);
        s = (ax >= 64'h8000_0000 || ay >= 64'h8000_0000 || az >= 64'h8000_0000) ? 1 : 0;
        ax = ax >> s; ay = ay >> s; az = az >> s;
        len = int_sqrt(ax * ax + ay * ay + az * az);
        if (len != 0) begin
          x0 = (az * longint'({32'd0, sh_r0[idx]})) / len;
          rz = (dz < 0) ? dz + longint'(x0) : dz - longint'(x0);
          q = (longint'({32'd0, sh_k[idx]}) * mag(rz)) >> 16;
          if (rz > 0) acc = acc - longint'(q);
          else acc = acc + longint'(q);
        end
      end
    end
    if (acc > FORCE_HI) acc = FORCE_HI;
    if (acc < FORCE_LO) acc = FORCE_LO;
    return acc[47:0];
  endfunction

  // f*dt^2/m, capped at 2^40
  function automatic longint accel(logic signed [47:0] f, logic [31:0] m);
    logic [127:0] prod, quo;
    longint unsigned fm;
    longint r;
    if (m == 0 || f == 0) return 0;
    fm = mag(longint'(f));
    prod = {64'd0, fm} * {80'd0, sh_dt2};
    prod = prod >> (DT2_FRAC - 16);
    quo = prod / {96'd0, m};
    r = (quo >= (128'd1 << 40)) ? (64'sd1 <<< 40) : longint'(quo[63:0]);
    return (f < 0) ? -r : r;
  endfunction

  function automatic void push_result(int a, logic [31:0] z, bit last);
    atom_res_t e;
    e.atom = 6'(a); e.x = sh_x[a]; e.y = sh_y[a]; e.z = z;
    e.f = sh_fz[a]; e.last = last;
    atom_results_q.insert(atom_results_q.size(), e);
  endfunction

  // update shadow state for one accepted beat, queue its results
  function automatic void verlet_predict(beat_t b);
    int n, a, idx;
    longint z;
    a = b.atom;
    case (b.cmd)
      CMD_LOAD_ATOM: begin
        sh_x[a] = b.x; sh_y[a] = b.y; sh_z[a] = b.z; sh_zold[a] = b.pz;
        sh_mass[a] = b.mass;
        sh_cnt[a] = (b.nc > 4) ? 3'd4 : b.nc;
      end
      CMD_LOAD_BOND: begin
        idx = a * 4 + b.slot;
        sh_part[idx] = b.part; sh_k[idx] = b.k; sh_r0[idx] = b.r0;
      end
      CMD_READ_ATOM: push_result(a, sh_z[a], 1'b1);
      default: begin
        n = (sh_atoms > 64) ? 64 : sh_atoms;
        for (int i = 0; i < n; i++) sh_fz[i] = bond_force(i, n);
        for (int i = 0; i < n; i++) begin
          z = 2 * longint'(sh_z[i]) - longint'(sh_zold[i]) + accel(sh_fz[i], sh_mass[i]);
          if (z > Z_HI) z = Z_HI;
          if (z < Z_LO) z = Z_LO;
          sh_zold[i] = sh_z[i];
          sh_z[i] = z[31:0];
          push_result(i, z[31:0], i + 1 == n);
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  // result side: check accepted beats, random stalls, long hold on request
  initial begin
    atom_res_t e;
    logic [5:0] g_atom;
    int stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        g_atom = m_axis_tdata[5:0];
        if (atom_results_q.size() == 0) begin
          report_mismatch("unexpected beat, atom", g_atom, 0);
        end else begin
          e = atom_results_q.pop_front();
          if (g_atom !== e.atom) report_mismatch("atom", g_atom, e.atom);
          if (m_axis_tdata[37:6] !== e.x) report_mismatch("x", m_axis_tdata[37:6], e.x);
          if (m_axis_tdata[69:38] !== e.y) report_mismatch("y", m_axis_tdata[69:38], e.y);
          if (m_axis_tdata[101:70] !== e.z) report_mismatch("z", m_axis_tdata[101:70], e.z);
          if (m_axis_tdata[149:102] !== e.f)
            report_mismatch("force_z", m_axis_tdata[149:102], e.f);
          if (m_axis_tlast !== e.last) report_mismatch("last", m_axis_tlast, e.last);
        end
      end
      if (hold_req) begin
        hold_req = 0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall = gap_len();
      end
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_in(beat_t b);
    return {7'd0, b.r0, b.k, b.part, b.mass, b.pz, b.z, b.y, b.x, b.nc, b.slot, b.atom};
  endfunction

  // one input beat, then a random gap; called just after a rising edge
  task automatic send_beat(beat_t b, bit typed = 0, logic [31:0] tz = 0, logic [47:0] tf = 0);
    int g;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_in(b);
    s_axis_tuser  <= b.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    verlet_predict(b);
    if (typed) begin
      atom_results_q[$].z = tz;
      atom_results_q[$].f = tf;
    end
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // register write, only once the block has drained
  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    s_axis_tvalid <= 1'b0;
    wait (atom_results_q.size() == 0);
    repeat (IDLE_PAUSE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_ATOM_COUNT) sh_atoms = val[6:0];
    else sh_dt2 = val;
  endtask

  function automatic beat_t blank(cmd_e c, int a);
    beat_t b;
    b.cmd = c; b.atom = 6'(a); b.slot = 0; b.nc = 0;
    b.x = 0; b.y = 0; b.z = 0; b.pz = 0; b.mass = 0;
    b.part = 0; b.k = 0; b.r0 = 0;
    return b;
  endfunction

  function automatic void row_cfg(logic [1:0] idx, logic [47:0] val);
    row_t r;
    r.is_cfg = 1; r.idx = idx; r.val = val; r.typed = 0; r.tz = 0; r.tf = 0;
    r.b = blank(CMD_RUN_STEP, 0);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void row_beat(beat_t b, bit typed = 0, logic [31:0] tz = 0,
                                   logic [47:0] tf = 0);
    row_t r;
    r.is_cfg = 0; r.idx = 0; r.val = 0; r.b = b; r.typed = typed; r.tz = tz; r.tf = tf;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void row_atom(int a, int nc, logic [31:0] x, y, z, pz, m);
    beat_t b;
    b = blank(CMD_LOAD_ATOM, a);
    b.nc = 3'(nc); b.x = x; b.y = y; b.z = z; b.pz = pz; b.mass = m;
    row_beat(b);
  endfunction

  function automatic void row_bond(int a, int s, int p, logic [31:0] k, r0);
    beat_t b;
    b = blank(CMD_LOAD_BOND, a);
    b.slot = 2'(s); b.part = 6'(p); b.k = k; b.r0 = r0;
    row_beat(b);
  endfunction

  // neighbor counts stay within the two bond slots filled per atom
  function automatic beat_t rand_beat(cmd_e c, int n);
    beat_t b;
    b.cmd = c; b.atom = 6'($urandom); b.slot = 2'($urandom);
    b.nc = 3'($urandom_range(0, 2));
    b.x = $urandom; b.y = $urandom; b.z = $urandom; b.pz = $urandom;
    b.mass = $urandom;
    if (b.mass == 0) b.mass = 1;
    b.part = ($urandom % 2) ? 6'($urandom_range(0, n - 1)) : 6'($urandom);
    b.k = ($urandom % 2) ? $urandom : $urandom % 32'h0004_0000;
    b.r0 = $urandom;
    return b;
  endfunction

  // stimulus
  initial begin
    int counts[8];
    int items, r;
    logic [47:0] dt2;
    counts = '{1, 2, 5, 8, 3, 64, 4, 6};
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_LOAD_ATOM;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_ATOM_COUNT;
    cfg_data_i    <= '0;
    sh_atoms = 7'd1;
    sh_dt2 = 48'd0;
    for (int i = 0; i < 64; i++) sh_cnt[i] = 3'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: saturation both ways, then bonds with the special cases
    row_cfg(CFG_DT2, 48'd0);
    row_cfg(CFG_ATOM_COUNT, 48'd1);
    row_atom(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    row_beat(blank(CMD_RUN_STEP, 0), 1, 32'h7FFF_FFFF, 48'd0);
    row_beat(blank(CMD_RUN_STEP, 0));
    row_atom(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
    row_beat(blank(CMD_RUN_STEP, 0), 1, 32'h8000_0000, 48'd0);
    row_beat(blank(CMD_READ_ATOM, 0), 1, 32'h8000_0000, 48'd0);
    row_cfg(CFG_ATOM_COUNT, 48'd3);
    row_cfg(CFG_DT2, 48'hFFFF_FFFF_FFFF);
    // neighbor count too large on atom 1, atom 2 coincident with atom 0, zero mass
    row_atom(0, 2, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_8000, 32'h0, 32'h0001_0000);
    row_atom(1, 7, 32'h8000_0000, 32'hFFFF_0000, 32'h8000_0000, 32'h1234_5678, 32'hFFFF_FFFF);
    row_atom(2, 1, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_8000, 32'h0000_0001, 32'h0);
    row_bond(0, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    row_bond(0, 1, 2, 32'h0001_0000, 32'h0001_0000);
    row_bond(1, 0, 0, 32'h0002_0000, 32'h0);
    row_bond(1, 1, 63, 32'hFFFF_FFFF, 32'h0001_0000);
    row_bond(1, 2, 1, 32'hFFFF_FFFF, 32'h0001_0000);
    row_bond(1, 3, 2, 32'h0000_0001, 32'h7FFF_FFFF);
    row_bond(2, 0, 0, 32'h0100_0000, 32'h0);
    row_beat(blank(CMD_RUN_STEP, 0));
    row_beat(blank(CMD_READ_ATOM, 2));
    // zero atom count: no beat out
    row_cfg(CFG_ATOM_COUNT, 48'd0);
    row_beat(blank(CMD_RUN_STEP, 0));
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].idx, dir_rows[i].val);
      else send_beat(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].tz, dir_rows[i].tf);
    end

    // fill every atom and two bond slots each, one full step, then reads under a long hold-off
    write_reg(CFG_ATOM_COUNT, 48'd64);
    write_reg(CFG_DT2, 48'({$urandom, $urandom}));
    for (int a = 0; a < 64; a++) begin
      beat_t b;
      b = rand_beat(CMD_LOAD_ATOM, 64);
      b.atom = 6'(a);
      send_beat(b);
    end
    for (int s = 0; s < 128; s++) begin
      beat_t b;
      b = rand_beat(CMD_LOAD_BOND, 64);
      b.atom = 6'(s / 2);
      b.slot = 2'(s % 2);
      send_beat(b);
    end
    send_beat(blank(CMD_RUN_STEP, 0));
    s_axis_tvalid <= 1'b0;
    wait (atom_results_q.size() == 0);
    @(posedge clk_i);
    hold_req = 1;
    for (int i = 0; i < 4; i++) send_beat(rand_beat(CMD_READ_ATOM, 64));

    // random phases, each with its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: dt2 = 48'hFFFF_FFFF_FFFF;
        1: dt2 = 48'd0;
        2: dt2 = 48'($urandom % 65536);
        default: dt2 = 48'({$urandom, $urandom});
      endcase
      write_reg(CFG_ATOM_COUNT, 48'(counts[ph]));
      write_reg(CFG_DT2, dt2);
      items = (counts[ph] == 64) ? 3 : 14;
      for (int i = 0; i < items; i++) begin
        r = $urandom % 10;
        if (r < 2) send_beat(rand_beat(CMD_RUN_STEP, counts[ph]));
        else if (r < 5) send_beat(rand_beat(CMD_LOAD_ATOM, counts[ph]));
        else if (r < 8) send_beat(rand_beat(CMD_LOAD_BOND, counts[ph]));
        else send_beat(rand_beat(CMD_READ_ATOM, counts[ph]));
      end
    end

    s_axis_tvalid <= 1'b0;
    wait (atom_results_q.size() == 0);
    repeat (IDLE_PAUSE * 2) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### harmonic_bond_verlet_step.f
+incdir+src
src/hbvs_pkg.sv
src/hbvs_ctrl.sv
src/hbvs_dp.sv
src/harmonic_bond_verlet_step.sv
tb/harmonic_bond_verlet_step_tb.sv
